/* sv/fal_pkg.sv */
// shared types and codes for the fixed array list
`default_nettype none
package fal_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_VALUE_BITS = 32;

	typedef enum logic [2:0] {
		OP_INS_REAR = 3'd0,
		OP_INS_AT   = 3'd1,
		OP_REM_REAR = 3'd2,
		OP_REM_AT   = 3'd3,
		OP_DUMP     = 3'd4
	} op_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_BADIDX = 2'd3;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_ROTATE
	} cell_cmd_t;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

endpackage
`default_nettype wire

/* sv/fal_cell.sv */
// one storage cell of the list, fed by its left and right neighbors
`default_nettype none
module fal_cell #(
	parameter int VALUE_BITS = 32,
	parameter int IW         = 4,
	parameter int INDEX      = 0
) (
	input  wire                    clk,
	input  wire fal_pkg::cell_cmd_t cmd,
	input  wire  [IW-1:0]          pos,
	input  wire  [IW-1:0]          last_idx,
	input  wire  [VALUE_BITS-1:0]  new_value,
	input  wire  [VALUE_BITS-1:0]  left_value,
	input  wire  [VALUE_BITS-1:0]  right_value,
	input  wire  [VALUE_BITS-1:0]  head_value,
	output logic [VALUE_BITS-1:0]  value
);
	import fal_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic [VALUE_BITS-1:0] value_q;

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_INSERT: begin
				if (MY_IDX > pos) begin
					value_q <= left_value;
				end else if (MY_IDX == pos) begin
					value_q <= new_value;
				end
			end
			CMD_REMOVE: begin
				if (MY_IDX >= pos) begin
					value_q <= right_value;
				end
			end
			CMD_ROTATE: begin
				// head wraps around to the last occupied cell
				if (MY_IDX == last_idx) begin
					value_q <= head_value;
				end else if (MY_IDX < last_idx) begin
					value_q <= right_value;
				end
			end
			default: begin
			end
		endcase
	end

	assign value = value_q;

endmodule
`default_nettype wire

/* sv/fal_ctrl.sv */
// operation decode, element count, dump sequencer and output register
`default_nettype none
module fal_ctrl #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32,
	parameter int IW         = 4,
	parameter int CW         = 5
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire  [2:0]             opcode,
	input  wire  [3:0]             position,
	input  wire  [VALUE_BITS-1:0]  head_value,
	output fal_pkg::cell_cmd_t     cmd,
	output logic [IW-1:0]          cell_pos,
	output logic [IW-1:0]          last_idx,
	output logic                   out_valid,
	input  wire                    out_stall,
	output logic [1:0]             status,
	output logic [31:0]            read_value,
	output logic [3:0]             read_index,
	output logic [4:0]             entry_count,
	output logic                   last
);
	import fal_pkg::*;

	localparam int CMPW = (CW > 5) ? CW : 5;
	localparam logic [CMPW-1:0] CAP_W = CMPW'(CAPACITY);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [IW-1:0]   idx_q, idx_d;
	logic            out_valid_q, out_valid_d;
	logic [1:0]      status_q;
	logic [31:0]     read_value_q;
	logic [3:0]      read_index_q;
	logic [4:0]      entry_count_q;
	logic            last_q;

	logic            accept, out_free, load;
	logic [1:0]      ld_status;
	logic [31:0]     ld_value;
	logic [3:0]      ld_index;
	logic            ld_last;
	logic [CMPW-1:0] pos_w, cnt_w, lastw, idx_w, cnt_new_w;
	logic [63:0]     head_ext;

	assign pos_w    = CMPW'(position);
	assign cnt_w    = CMPW'(count_q);
	assign lastw    = cnt_w - CMPW'(1);
	assign idx_w    = CMPW'(idx_q);
	assign head_ext = 64'(head_value);
	assign last_idx = lastw[IW-1:0];

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		cmd       = CMD_HOLD;
		cell_pos  = pos_w[IW-1:0];
		load      = 1'b0;
		ld_status = ST_OK;
		ld_value  = '0;
		ld_index  = '0;
		ld_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					load = 1'b1;
					unique case (op_t'(opcode))
						OP_INS_REAR: begin
							if (cnt_w >= CAP_W) begin
								ld_status = ST_FULL;
							end else begin
								cmd      = CMD_INSERT;
								cell_pos = cnt_w[IW-1:0];
								count_d  = CW'(count_q + CW'(1));
							end
						end
						OP_INS_AT: begin
							if (cnt_w >= CAP_W) begin
								ld_status = ST_FULL;
							end else if (pos_w > cnt_w) begin
								ld_status = ST_BADIDX;
							end else begin
								cmd     = CMD_INSERT;
								count_d = CW'(count_q + CW'(1));
							end
						end
						OP_REM_REAR: begin
							if (count_q == '0) begin
								ld_status = ST_EMPTY;
							end else begin
								count_d = CW'(count_q - CW'(1));
							end
						end
						OP_REM_AT: begin
							if (count_q == '0) begin
								ld_status = ST_EMPTY;
							end else if (pos_w >= cnt_w) begin
								ld_status = ST_BADIDX;
							end else begin
								cmd     = CMD_REMOVE;
								count_d = CW'(count_q - CW'(1));
							end
						end
						OP_DUMP: begin
							if (count_q == '0) begin
								ld_status = ST_EMPTY;
							end else begin
								// results come from the dump sequencer instead
								load    = 1'b0;
								idx_d   = '0;
								state_d = S_DUMP;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_DUMP: begin
				if (out_free) begin
					load     = 1'b1;
					cmd      = CMD_ROTATE;
					ld_value = head_ext[31:0];
					ld_index = idx_w[3:0];
					ld_last  = (idx_w == lastw);
					idx_d    = IW'(idx_q + IW'(1));
					if (idx_w == lastw) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
		cnt_new_w = CMPW'(count_d);
		if (load) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q      <= ld_status;
			read_value_q  <= ld_value;
			read_index_q  <= ld_index;
			entry_count_q <= cnt_new_w[4:0];
			last_q        <= ld_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign read_index  = read_index_q;
	assign entry_count = entry_count_q;
	assign last        = last_q;

endmodule
`default_nettype wire

/* sv/fixed_array_list.sv */
// top level of the fixed array list: row of cells plus controller
// Ordered list of up to CAPACITY values held in a row of cells, one value per
// cell, all cells shifting together. Insert and remove (at the rear or at an
// index) and refused operations each give one result transaction, registered and
// shown the cycle after acceptance. A dump of a list of n elements holds the
// input from its acceptance until its last element is read out and gives n
// transactions, head first: the state register moves to dump, then the first
// result is registered. The row rotates one place per cycle while the output
// register is free, and the head cell is read out, so after the dump the list
// is back in its original order. The input is stalled while a dump runs and
// while the output register holds a result that is itself stalled.
`default_nettype none
module fixed_array_list #(
	parameter int CAPACITY   = fal_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = fal_pkg::DEF_VALUE_BITS
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [2:0]  opcode,
	input  wire  [3:0]  position,
	input  wire  [31:0] item_value,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  status,
	output logic [31:0] read_value,
	output logic [3:0]  read_index,
	output logic [4:0]  entry_count,
	output logic        last
);
	import fal_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	cell_cmd_t             cmd;
	logic [IW-1:0]         cell_pos;
	logic [IW-1:0]         last_idx;
	logic [63:0]           item_ext;
	logic [VALUE_BITS-1:0] new_value;
	logic [VALUE_BITS-1:0] cell_val [CAPACITY];

	assign item_ext  = 64'(item_value);
	assign new_value = item_ext[VALUE_BITS-1:0];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] left_v, right_v;
		if (i == 0) begin : g_first
			assign left_v = new_value;
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_v = cell_val[i];
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end
		fal_cell #(
			.VALUE_BITS (VALUE_BITS),
			.IW         (IW),
			.INDEX      (i)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.pos         (cell_pos),
			.last_idx    (last_idx),
			.new_value   (new_value),
			.left_value  (left_v),
			.right_value (right_v),
			.head_value  (cell_val[0]),
			.value       (cell_val[i])
		);
	end

	fal_ctrl #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS),
		.IW         (IW),
		.CW         (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.position    (position),
		.head_value  (cell_val[0]),
		.cmd         (cmd),
		.cell_pos    (cell_pos),
		.last_idx    (last_idx),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_value  (read_value),
		.read_index  (read_index),
		.entry_count (entry_count),
		.last        (last)
	);

endmodule
`default_nettype wire

/* sv/fal_check.sv */
// port-level assertions for the fixed array list, bound to the top level
`default_nettype none
module fal_check (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [1:0]  status,
	input wire [31:0] read_value,
	input wire [3:0]  read_index,
	input wire [4:0]  entry_count,
	input wire        last
);
	import fal_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(read_value)
			&& $stable(read_index) && $stable(entry_count) && $stable(last))
		else $error("stalled result payload changed");

	a_refusal_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last && read_value == 32'd0
			&& read_index == 4'd0)
		else $error("refusal not a single clean transaction");

	a_dump_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> status == ST_OK && in_stall)
		else $error("unfinished dump with bad status or open input");

	// the next dump element follows right behind the one just taken
	a_dump_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid
			&& read_index == 4'($past(read_index) + 4'd1))
		else $error("dump transactions not consecutive");

endmodule

bind fixed_array_list fal_check u_fal_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.read_value  (read_value),
	.read_index  (read_index),
	.entry_count (entry_count),
	.last        (last)
);
`default_nettype wire

/* tb/sv/tb_fixed_array_list.sv */
// self-checking testbench for the fixed array list: driver, monitor and list predictor
`default_nettype none
module tb_fixed_array_list;
	timeunit 1ns;
	timeprecision 1ps;

	import fal_pkg::*;

	localparam int          LIST_DEPTH  = DEF_CAPACITY;
	localparam int          RAND_ITEMS  = 450;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          CALM_TAIL   = 60;
	localparam int          DRAIN_WAIT  = 20;
	localparam logic [2:0]  OP_SPARE_5  = 3'd5;
	localparam logic [2:0]  OP_SPARE_6  = 3'd6;
	localparam logic [2:0]  OP_SPARE_7  = 3'd7;

	typedef struct {
		logic [2:0]  opcode;
		logic [3:0]  pos;
		logic [31:0] value;
	} list_op_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
		logic [3:0]  index;
		logic [4:0]  count;
		logic        last;
	} list_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = '0;
	logic [3:0]  position = '0;
	logic [31:0] item_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] read_value;
	logic [3:0]  read_index;
	logic [4:0]  entry_count;
	logic        last;

	fixed_array_list uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.position(position),
		.item_value(item_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.read_value(read_value),
		.read_index(read_index),
		.entry_count(entry_count),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	list_op_t     op_queue[$];
	list_report_t awaited_reports[$];

	// predicted list contents
	logic [31:0] list_cells[LIST_DEPTH];
	logic [4:0]  list_count = '0;

	int gen_count = 0;
	int rand_items = 0;
	int ops_applied = 0;
	int reports_checked = 0;
	int refusals_seen = 0;
	int dump_reads = 0;
	int full_hits = 0;
	int mismatches = 0;
	int cycles = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	logic calm = 1'b0;

	task automatic apply_list_op(input logic [2:0] op, input logic [3:0] pos,
			input logic [31:0] val);
		logic [1:0]   st;
		int           i;
		list_report_t r;
		st = ST_OK;
		case (op)
			OP_INS_REAR: begin
				if (list_count >= LIST_DEPTH) begin
					st = ST_FULL;
				end else begin
					list_cells[list_count] = val;
					list_count++;
				end
			end
			OP_INS_AT: begin
				if (list_count >= LIST_DEPTH) begin
					st = ST_FULL;
				end else if (pos > list_count) begin
					st = ST_BADIDX;
				end else begin
					for (i = list_count; i > pos; i--)
						list_cells[i] = list_cells[i - 1];
					list_cells[pos] = val;
					list_count++;
				end
			end
			OP_REM_REAR: begin
				if (list_count == 0)
					st = ST_EMPTY;
				else
					list_count--;
			end
			OP_REM_AT: begin
				if (list_count == 0) begin
					st = ST_EMPTY;
				end else if (pos >= list_count) begin
					st = ST_BADIDX;
				end else begin
					for (i = pos; i + 1 < list_count; i++)
						list_cells[i] = list_cells[i + 1];
					list_count--;
				end
			end
			OP_DUMP: begin
				if (list_count == 0)
					st = ST_EMPTY;
			end
			default: ;
		endcase
		if (list_count == LIST_DEPTH)
			full_hits++;
		if (op == OP_DUMP && list_count != 0) begin
			// one transaction per element, head first
			for (i = 0; i < list_count; i++) begin
				r.status = ST_OK;
				r.value = list_cells[i];
				r.index = i[3:0];
				r.count = list_count;
				r.last = (i + 1 == list_count);
				awaited_reports.push_back(r);
			end
		end else begin
			r.status = st;
			r.value = '0;
			r.index = '0;
			r.count = list_count;
			r.last = 1'b1;
			awaited_reports.push_back(r);
		end
	endtask

	// stimulus side keeps only the element count to steer sequences
	function automatic void queue_op(input logic [2:0] op, input int pos,
			input logic [31:0] val);
		list_op_t o;
		o.opcode = op;
		o.pos = pos[3:0];
		o.value = val;
		op_queue.push_back(o);
		case (op)
			OP_INS_REAR: if (gen_count < LIST_DEPTH) gen_count++;
			OP_INS_AT:   if (gen_count < LIST_DEPTH && pos <= gen_count) gen_count++;
			OP_REM_REAR: if (gen_count > 0) gen_count--;
			OP_REM_AT:   if (gen_count > 0 && pos < gen_count) gen_count--;
			default: ;
		endcase
		if (op <= OP_DUMP)
			rand_items++;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_pos(input int hi);
		if ($urandom_range(0, 3) == 0 || hi > 15)
			return $urandom_range(0, 15);
		return $urandom_range(0, hi);
	endfunction

	task automatic build_stimulus();
		int n;
		int k;
		logic [2:0] op;
		// corner cases on an empty list
		queue_op(OP_DUMP, 0, '0);
		queue_op(OP_REM_REAR, 0, '0);
		queue_op(OP_REM_AT, 0, '0);
		queue_op(OP_INS_AT, 3, 32'h1234_5678);
		queue_op(OP_SPARE_7, 15, 32'hffff_ffff);
		// build up, insert at the count and in the middle
		queue_op(OP_INS_REAR, 0, 32'h0000_0000);
		queue_op(OP_INS_REAR, 15, 32'hffff_ffff);
		queue_op(OP_INS_AT, 0, 32'haaaa_aaaa);
		queue_op(OP_INS_AT, 3, 32'h5555_5555);
		queue_op(OP_INS_AT, 1, 32'h8000_0001);
		queue_op(OP_INS_AT, 15, 32'h7fff_fffe);
		queue_op(OP_DUMP, 0, '0);
		queue_op(OP_REM_AT, 15, '0);
		queue_op(OP_REM_AT, 5, '0);
		queue_op(OP_REM_AT, 2, '0);
		queue_op(OP_REM_AT, 0, '0);
		queue_op(OP_REM_REAR, 0, '0);
		queue_op(OP_SPARE_5, 5, 32'h0f0f_0f0f);
		queue_op(OP_SPARE_6, 10, 32'hf0f0_f0f0);
		queue_op(OP_DUMP, 0, '0);
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					// fill to the top, then knock on the full list
					while (gen_count < LIST_DEPTH) begin
						if ($urandom_range(0, 1))
							queue_op(OP_INS_REAR, $urandom_range(0, 15), pick_value());
						else
							queue_op(OP_INS_AT, $urandom_range(0, gen_count), pick_value());
					end
					n = $urandom_range(1, 2);
					for (k = 0; k < n; k++)
						queue_op($urandom_range(0, 1) ? OP_INS_REAR : OP_INS_AT,
							$urandom_range(0, 15), pick_value());
					if ($urandom_range(0, 1))
						queue_op(OP_DUMP, $urandom_range(0, 15), $urandom);
				end
				3, 4: begin
					while (gen_count > 0) begin
						if ($urandom_range(0, 1))
							queue_op(OP_REM_REAR, $urandom_range(0, 15), $urandom);
						else
							queue_op(OP_REM_AT, $urandom_range(0, gen_count - 1), $urandom);
					end
					queue_op($urandom_range(0, 1) ? OP_REM_REAR : OP_REM_AT,
						$urandom_range(0, 15), $urandom);
					if ($urandom_range(0, 1))
						queue_op(OP_DUMP, 0, '0);
				end
				5, 6, 7: begin
					n = $urandom_range(4, 12);
					for (k = 0; k < n; k++) begin
						case ($urandom_range(0, 9))
							0, 1, 2: op = OP_INS_REAR;
							3, 4:    op = OP_INS_AT;
							5:       op = OP_REM_REAR;
							6, 7:    op = OP_REM_AT;
							default: op = OP_DUMP;
						endcase
						if (op == OP_INS_AT)
							queue_op(op, pick_pos(gen_count), pick_value());
						else
							queue_op(op, pick_pos(gen_count > 0 ? gen_count - 1 : 0), pick_value());
					end
				end
				8: queue_op(OP_DUMP, $urandom_range(0, 15), $urandom);
				default: begin
					// noise: spare opcodes and wild positions
					if ($urandom_range(0, 1))
						queue_op(3'($urandom_range(OP_SPARE_5, OP_SPARE_7)),
							$urandom_range(0, 15), $urandom);
					else
						queue_op(3'($urandom_range(OP_INS_REAR, OP_DUMP)),
							$urandom_range(0, 15), $urandom);
				end
			endcase
		end
	endtask

	// idle and stall densities shift over the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 64 == 0) begin
			case ($urandom_range(0, 3))
				0: gap_pct <= 0;
				1: gap_pct <= 10;
				2: gap_pct <= 30;
				default: gap_pct <= 60;
			endcase
			case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 10;
				2: stall_pct <= 30;
				default: stall_pct <= 60;
			endcase
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still awaited",
				cycles, awaited_reports.size());
			$display("FAILURE");
			$finish;
		end
	end

	// driver
	int gap_left = 0;
	always @(posedge clk) begin
		list_op_t cur;
		logic     nxt_valid;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				apply_list_op(opcode, position, item_value);
				ops_applied++;
			end
			calm <= (op_queue.size() < CALM_TAIL);
			if (!in_valid || !in_stall) begin
				nxt_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (op_queue.size() < CALM_TAIL ||
						$urandom_range(0, 99) >= gap_pct) begin
					if (op_queue.size() > 0) begin
						cur = op_queue.pop_front();
						opcode <= cur.opcode;
						position <= cur.pos;
						item_value <= cur.value;
						nxt_valid = 1'b1;
					end
				end else begin
					gap_left = $urandom_range(0, 7);
				end
				in_valid <= nxt_valid;
			end
		end
	end

	// monitor
	int stall_left = 0;
	always @(posedge clk) begin
		list_report_t want;
		logic         nxt_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				reports_checked++;
				if (awaited_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"unexpected result transaction: status %0d value %h",
							" index %0d count %0d last %0b"},
							status, read_value, read_index, entry_count, last);
				end else begin
					want = awaited_reports.pop_front();
					if (status != ST_OK)
						refusals_seen++;
					else if (read_index != 0 || want.index != 0 || !last)
						dump_reads++;
					if (status !== want.status || read_value !== want.value ||
							read_index !== want.index || entry_count !== want.count ||
							last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch at cycle %0d: expected status %0d value %h",
								" index %0d count %0d last %0b, got status %0d value %h",
								" index %0d count %0d last %0b"},
								cycles, want.status, want.value, want.index, want.count,
								want.last, status, read_value, read_index, entry_count,
								last);
					end
				end
			end
			nxt_stall = 1'b0;
			if (stall_left > 0) begin
				stall_left--;
				nxt_stall = 1'b1;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(0, 7);
				nxt_stall = 1'b1;
			end
			out_stall <= nxt_stall;
		end
	end

	initial begin
		build_stimulus();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait (op_queue.size() == 0 && !in_valid);
		wait (awaited_reports.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("%0d list operations applied, %0d result transactions checked", ops_applied,
			reports_checked);
		$display("%0d refusals, %0d dump reads, list full after %0d operations, %0d mismatches",
			refusals_seen, dump_reads, full_hits, mismatches);
		if (mismatches == 0 && awaited_reports.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
`default_nettype wire
